### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Types and constants shared by the Merkle path direction block.
// ----------------------------------------------------------------------------
package mpd_pkg;

  // Width of the level field.
  localparam int LEVEL_W = 6;
  // Width used to compare the step count with the requested level.
  localparam int CMP_W = 7;

  // One bit position of the walk: last leaf index (size - 1) and leaf index.
  typedef struct packed {
    logic m;
    logic i;
  } mpd_bits_t;

  // Control of the shift chain.
  typedef struct packed {
    logic load;
    logic shift;
  } mpd_cell_ctrl_t;

  // Control of the scan unit at the head of the chain.
  typedef struct packed {
    logic init;
    logic run;
  } mpd_scan_ctrl_t;

  // Outcome of one transaction.
  typedef struct packed {
    logic found;
    logic goes_right;
  } mpd_result_t;

endpackage

### rtl/mpd_cell.sv
// ----------------------------------------------------------------------------
// mpd_cell
// One bit position of the shift chain; passes its bits toward the head.
// ----------------------------------------------------------------------------
module mpd_cell
  import mpd_pkg::*;
(
  input  logic           clk,
  input  mpd_cell_ctrl_t ctrl,
  input  mpd_bits_t      load_bits,
  input  mpd_bits_t      prev_bits,
  output mpd_bits_t      bits
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bits <= load_bits;
    end else if (ctrl.shift) begin
      bits <= prev_bits;
    end
  end

endmodule

### rtl/mpd_scan.sv
// ----------------------------------------------------------------------------
// mpd_scan
// Walks the tree one bit position per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mpd_scan
  import mpd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  mpd_scan_ctrl_t     ctrl,
  input  logic [LEVEL_W-1:0] level_in,
  input  logic               small_in,
  input  mpd_bits_t          head,
  output mpd_result_t        result
);

  localparam int STEP_W = $clog2(COUNT_BITS + 1);

  logic [STEP_W-1:0]  step_cnt;
  logic [LEVEL_W-1:0] want;
  logic               tiny;
  logic               all_ones;
  logic               eq;
  logic               gt;
  logic               hit;
  logic               dir;

  logic step;
  logic hit_now;

  // A tree level is split at this position when the left subtree was taken
  // above, or when the remaining last index has this bit set.
  always_comb begin
    step    = all_ones | head.m;
    hit_now = step & ~hit & (CMP_W'(step_cnt) == CMP_W'(want));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      all_ones <= 1'b0;
      eq       <= 1'b1;
      gt       <= 1'b0;
      hit      <= 1'b0;
      tiny     <= 1'b1;
    end else if (ctrl.init) begin
      step_cnt <= '0;
      all_ones <= 1'b0;
      eq       <= 1'b1;
      gt       <= 1'b0;
      hit      <= 1'b0;
      tiny     <= small_in;
    end else if (ctrl.run) begin
      if (step) begin
        step_cnt <= step_cnt + STEP_W'(1);
        all_ones <= all_ones | ~head.i;
      end
      if (hit_now) begin
        hit <= 1'b1;
      end
      // Serial check that the leaf index does not exceed the last index.
      if (eq && (head.i != head.m)) begin
        eq <= 1'b0;
        gt <= head.i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      want <= level_in;
      dir  <= 1'b0;
    end else if (ctrl.run && hit_now) begin
      dir <= head.i;
    end
  end

  always_comb begin
    result.found      = hit & ~gt & ~tiny;
    result.goes_right = hit & ~gt & ~tiny & dir;
  end

endmodule

### rtl/merkle_path_direction_top.sv
// A transaction is accepted at an edge where start is high and busy is low;
// busy is high for the walk, and the result strobe follows the walk's end.
// A new transaction is taken only once the walk of the last one is over, at
// the earliest in its strobe cycle; the bit chain is shifted past the scan unit one position per cycle during the walk.
// Reset: rst is synchronous and active high; it returns the block to idle.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
// merkle_path_direction_top
// Direction of a leaf's path at one level of an unbalanced Merkle tree.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module merkle_path_direction_top
  import mpd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        tree_size,
  input  logic [31:0]        leaf_index,
  input  logic [LEVEL_W-1:0] level,
  output logic               strobe,
  output logic               found,
  output logic               goes_right
);

  // The tree is walked by looking at the last leaf index m = size - 1 and
  // at the leaf index, most significant bit first. The split point of a
  // node is the top set bit of m. Going right clears that bit in both
  // values; going left leaves a full power-of-two subtree, so every lower
  // position is then a split. The direction at a split is the index bit.

  localparam int CNT_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(COUNT_BITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;

  logic                  accept;
  logic [COUNT_BITS-1:0] size_cw;
  logic [COUNT_BITS-1:0] idx_cw;
  logic [COUNT_BITS-1:0] last_cw;
  logic                  small_size;

  mpd_cell_ctrl_t cell_ctrl;
  mpd_scan_ctrl_t scan_ctrl;
  mpd_bits_t      chain [COUNT_BITS];
  mpd_bits_t      load_vec [COUNT_BITS];
  mpd_result_t    result;

  assign accept = start & ~busy;

  // Both counts are reduced to the datapath width before the walk.
  always_comb begin
    size_cw    = COUNT_BITS'(tree_size);
    idx_cw     = COUNT_BITS'(leaf_index);
    last_cw    = size_cw - COUNT_BITS'(1);
    small_size = (size_cw <= COUNT_BITS'(1));
  end

  // Sequencer: idle, a walk over every bit position, then the result strobe state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_RUN;
      end
      S_RUN: begin
        if (cnt == LAST) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = start ? S_RUN : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == S_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  assign busy   = (state == S_RUN);
  assign strobe = (state == S_DONE);

  always_comb begin
    cell_ctrl.load  = accept;
    cell_ctrl.shift = busy;
    scan_ctrl.init  = accept;
    scan_ctrl.run   = busy;
  end

  // Chain of bit cells; cell COUNT_BITS-1 is the head seen by the scan unit.
  for (genvar g = 0; g < COUNT_BITS; g++) begin : g_cell
    assign load_vec[g].m = last_cw[g];
    assign load_vec[g].i = idx_cw[g];

    if (g == 0) begin : g_tail
      mpd_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .load_bits (load_vec[g]),
        .prev_bits ('0),
        .bits      (chain[g])
      );
    end else begin : g_body
      mpd_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .load_bits (load_vec[g]),
        .prev_bits (chain[g-1]),
        .bits      (chain[g])
      );
    end
  end

  mpd_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (scan_ctrl),
    .level_in (level),
    .small_in (small_size),
    .head     (chain[COUNT_BITS-1]),
    .result   (result)
  );

  // Result ports carry data only during the strobe cycle.
  assign found      = strobe & result.found;
  assign goes_right = strobe & result.goes_right;

  `ASSERT_NEXT(a_accept_runs, accept, busy, "accepted transaction did not start the walk")
  `ASSERT_NEXT(a_last_done, busy && (cnt == LAST), strobe, "walk end gave no result strobe")
  `ASSERT_CLK(a_strobe_after_walk, strobe |-> $past(busy), "result strobe without a walk")
  `ASSERT_CLK(a_right_needs_found, goes_right |-> found, "direction reported without a hit")

endmodule

### tb/sv/merkle_path_direction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merkle_path_direction_checker
// Watches the input and result ports of the path direction block. It
// predicts the turn of each accepted transaction and compares the strobed
// results in order.
// ----------------------------------------------------------------------------
module merkle_path_direction_checker
  import mpd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [31:0]        tree_size,
  input  logic [31:0]        leaf_index,
  input  logic [LEVEL_W-1:0] level,
  input  logic               strobe,
  input  logic               found,
  input  logic               goes_right,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [31:0]        size;
    logic [31:0]        index;
    logic [LEVEL_W-1:0] lvl;
    mpd_result_t        turn;
  } path_query_t;

  path_query_t turn_q[$];
  int          errs;

  // Walks the tree from the root; each node of n > 1 leaves splits off the
  // largest power of two strictly below n as its left subtree.
  function automatic mpd_result_t path_turn(input logic [31:0] size_in,
                                            input logic [31:0] idx_in,
                                            input logic [LEVEL_W-1:0] want);
    logic [63:0] mask;
    logic [63:0] size;
    logic [63:0] idx;
    logic [63:0] k;
    int          step;
    mpd_result_t r;
    mask = (COUNT_BITS >= 64) ? '1 : ((64'd1 << COUNT_BITS) - 64'd1);
    size = {32'd0, size_in} & mask;
    idx  = {32'd0, idx_in} & mask;
    r    = '0;
    step = 0;
    if (size <= 1 || idx >= size) return r;
    while (size > 1) begin
      k = 64'd1;
      while ((k << 1) < size) k = k << 1;
      if (step == want) begin
        r.found      = 1'b1;
        r.goes_right = (idx >= k);
        return r;
      end
      step++;
      if (idx >= k) begin
        size = size - k;
        idx  = idx - k;
      end else begin
        size = k;
      end
    end
    return r;
  endfunction

  initial begin
    errs       = 0;
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    path_query_t q;
    if (!rst) begin
      // The result strobe is handled before a new transaction is queued, so a
      // spurious strobe can never match the transaction accepted at this edge.
      if (strobe) begin
        if (turn_q.size() == 0) begin
          $display("%0t: stray result: expected none, actual found=%0b right=%0b",
                   $time, found, goes_right);
          errs++;
        end else begin
          q = turn_q.pop_front();
          if (found !== q.turn.found) begin
            $display("%0t: found (size %h idx %h lvl %0d): expected %0b, actual %0b",
                     $time, q.size, q.index, q.lvl, q.turn.found, found);
            errs++;
          end
          if (goes_right !== q.turn.goes_right) begin
            $display("%0t: goes_right (size %h idx %h lvl %0d): expected %0b, actual %0b",
                     $time, q.size, q.index, q.lvl, q.turn.goes_right, goes_right);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        q.size  = tree_size;
        q.index = leaf_index;
        q.lvl   = level;
        q.turn  = path_turn(tree_size, leaf_index, level);
        turn_q.push_back(q);
      end
    end
    fail_count <= errs;
    pending    <= turn_q.size();
  end

endmodule

### tb/sv/merkle_path_direction_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merkle_path_direction_top_test
// Drives leaf count, leaf index and level transactions into the path direction
// block: a directed set of corner cases, then random transactions under three
// idling patterns. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module merkle_path_direction_top_test
  import mpd_pkg::*;
();

  localparam int COUNT_BITS = 32;
  // Transactions per random phase; three phases make up the bulk of the run.
  localparam int PHASE_ITEMS = 430;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [31:0]        tree_size;
  logic [31:0]        leaf_index;
  logic [LEVEL_W-1:0] level;
  logic               strobe;
  logic               found;
  logic               goes_right;
  int                 fail_count;
  int                 pending;
  int                 drain;

  merkle_path_direction_top #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .tree_size (tree_size),
    .leaf_index(leaf_index),
    .level     (level),
    .strobe    (strobe),
    .found     (found),
    .goes_right(goes_right)
  );

  merkle_path_direction_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) path_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .tree_size (tree_size),
    .leaf_index(leaf_index),
    .level     (level),
    .strobe    (strobe),
    .found     (found),
    .goes_right(goes_right),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Presents one transaction and returns at the edge where it is accepted. On
  // each cycle start is dropped with probability idle_pct percent, and now
  // and then a longer burst of idle cycles is inserted, so that the moment of
  // launch moves across every cycle of the walk and of the result strobe.
  // Start gets exactly one nonblocking assignment per clock edge, so a start
  // that stays high for back-to-back transactions is never pulsed low.
  task automatic send_query(input logic [31:0] size_v, input logic [31:0] idx_v,
                            input logic [LEVEL_W-1:0] lvl_v, input int idle_pct);
    logic offer;
    int   burst;
    burst = (idle_pct > 0 && $urandom_range(0, 99) < 10) ? $urandom_range(1, 40) : 0;
    tree_size  <= size_v;
    leaf_index <= idx_v;
    level      <= lvl_v;
    forever begin
      offer = (burst == 0) && ($urandom_range(0, 99) >= idle_pct);
      if (burst > 0) burst--;
      start <= offer;
      @(posedge clk);
      // Busy is read before the block's own updates at this edge apply.
      if (offer && !busy) break;
    end
  endtask

  // Random transactions. Most are well formed: an index inside the tree and a
  // level of at most two past the deepest level that the tree can have. The
  // rest put the index just past the last leaf or are plain noise.
  task automatic run_phase(input int idle_pct, input int count);
    int                 shift;
    int                 kind;
    logic [31:0]        size_v;
    logic [31:0]        idx_v;
    logic [LEVEL_W-1:0] lvl_v;
    repeat (count) begin
      shift  = $urandom_range(0, 31);
      size_v = $urandom >> shift;
      kind   = $urandom_range(0, 99);
      if (kind < 75) begin
        idx_v = (size_v != 0) ? ($urandom % size_v) : $urandom;
        lvl_v = LEVEL_W'($urandom_range(0, 33 - shift));
      end else if (kind < 88) begin
        idx_v = size_v + $urandom_range(0, 3);
        lvl_v = LEVEL_W'($urandom_range(0, 7));
      end else begin
        size_v = $urandom;
        idx_v  = $urandom;
        lvl_v  = LEVEL_W'($urandom_range(0, 63));
      end
      send_query(size_v, idx_v, lvl_v, idle_pct);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    tree_size  = '0;
    leaf_index = '0;
    level      = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases: empty and single-leaf trees, an index at or
    // beyond the size, the largest tree at its first and deepest levels,
    // levels that lie past the leaf, and the highest level value.
    send_query(32'h0000_0000, 32'h0000_0000, 6'd0, 19);
    send_query(32'h0000_0001, 32'h0000_0000, 6'd0, 19);
    send_query(32'h0000_0002, 32'h0000_0000, 6'd0, 19);
    send_query(32'h0000_0002, 32'h0000_0001, 6'd0, 19);
    send_query(32'h0000_0002, 32'h0000_0001, 6'd1, 19);
    send_query(32'h0000_0002, 32'h0000_0002, 6'd0, 19);
    send_query(32'h0000_0005, 32'h0000_0007, 6'd0, 19);
    send_query(32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 19);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd0, 19);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd1, 19);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd31, 19);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd5, 19);
    send_query(32'hFFFF_FFFF, 32'h0000_0000, 6'd31, 19);
    send_query(32'hFFFF_FFFF, 32'h0000_0000, 6'd32, 19);
    send_query(32'hFFFF_FFFF, 32'h0000_0000, 6'd63, 19);
    send_query(32'h8000_0000, 32'h7FFF_FFFF, 6'd30, 19);
    send_query(32'h8000_0000, 32'h7FFF_FFFF, 6'd31, 19);
    send_query(32'h8000_0001, 32'h8000_0000, 6'd0, 19);
    send_query(32'h8000_0001, 32'h8000_0000, 6'd1, 19);
    send_query(32'h0000_0007, 32'h0000_0006, 6'd1, 19);
    send_query(32'h0000_0007, 32'h0000_0003, 6'd2, 19);
    send_query(32'hAAAA_AAAA, 32'h5555_5555, 6'd3, 19);
    send_query(32'h5555_5555, 32'h2AAA_AAAA, 6'd63, 19);
    send_query(32'h0000_0003, 32'h0000_0002, 6'd0, 19);
    send_query(32'h0000_0001, 32'h0000_0001, 6'd0, 19);

    // Light idling, then heavy idling, then transactions back to back.
    run_phase(19, PHASE_ITEMS);
    run_phase(69, PHASE_ITEMS);
    run_phase(0, PHASE_ITEMS);
    start <= 1'b0;

    // Drain: wait for every outstanding result, with a bound, then give the
    // block a walk's worth of cycles to show any stray strobe.
    drain = 0;
    while (pending != 0 && drain < 4 * (COUNT_BITS + 1) + 100) begin
      @(posedge clk);
      drain++;
    end
    repeat (COUNT_BITS + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the length of a typical correct run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
